### rtl/tape_machine_execute_unit_top_defines.svh
// Assertion macros for the tape machine execute unit.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef TAPE_MACHINE_EXECUTE_UNIT_TOP_DEFINES_SVH
`define TAPE_MACHINE_EXECUTE_UNIT_TOP_DEFINES_SVH

// Same-cycle implication.
`define TME_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tme_pkg.sv
// Shared types and constants of the tape machine execute unit.
// No dependencies.
package tme_pkg;

  localparam logic [3:0] MODE_RIGHT   = 4'd0;
  localparam logic [3:0] MODE_RIGHT_N = 4'd1;
  localparam logic [3:0] MODE_LEFT    = 4'd2;
  localparam logic [3:0] MODE_LEFT_N  = 4'd3;
  localparam logic [3:0] MODE_INC     = 4'd4;
  localparam logic [3:0] MODE_ADD     = 4'd5;
  localparam logic [3:0] MODE_DEC     = 4'd6;
  localparam logic [3:0] MODE_SUB     = 4'd7;
  localparam logic [3:0] MODE_PRINT   = 4'd8;
  localparam logic [3:0] MODE_STORE   = 4'd9;
  localparam logic [3:0] MODE_JUMP    = 4'd10;
  localparam logic [3:0] MODE_JZ      = 4'd11;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ADD,
    OP_SET,
    OP_PRINT,
    OP_JUMP,
    OP_JZ
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  operand;
    logic [15:0] target;
  } cmd_t;

  typedef struct packed {
    logic        printed;
    logic [7:0]  obyte;
    logic        take;
    logic [15:0] tgt;
  } res_t;

  localparam int QDEPTH    = 2;
  localparam int OUT_DEPTH = 4;
  localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic              clearing;
    logic              e2_v;
    logic [OCNT_W-1:0] ocount;
  } back_stat_t;

endpackage

### rtl/tme_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tme_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### rtl/tme_queue.sv
// Short FIFO of decoded commands between front and back.
// No dependencies.
module tme_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic         full,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_r, rd_r, wr_nxt, rd_nxt;
  logic [CW-1:0] cnt_r;

  assign wr_nxt = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
  assign rd_nxt = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
  assign head   = mem_r[rd_r];
  assign full   = (cnt_r == CW'(DEPTH));
  assign empty  = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_nxt;
      end
      if (pop) begin
        rd_r <= rd_nxt;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

### rtl/tme_front.sv
// Front end: decodes modes, owns the cell pointer, emits commands.
// Depends on tme_pkg.
module tme_front #(
  parameter int TAPE_CELLS        = 32768,
  parameter int PROGRAM_ADDR_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          acc,
  input  logic [3:0]                    mode,
  input  logic [7:0]                    amount,
  input  logic [15:0]                   target,
  input  logic [7:0]                    in_byte,
  output tme_pkg::cmd_t                 cmd,
  output logic [$clog2(TAPE_CELLS)-1:0] addr
);

  import tme_pkg::*;

  localparam int PTR_W = $clog2(TAPE_CELLS);
  localparam int SW    = ((PTR_W > 8) ? PTR_W : 8) + 1;
  localparam logic [SW-1:0] CELLS = SW'(TAPE_CELLS);
  localparam logic [15:0] TGT_MASK = (PROGRAM_ADDR_BITS >= 16) ? 16'hFFFF :
                                     16'((32'd1 << PROGRAM_ADDR_BITS) - 32'd1);

  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic [7:0]       rem;

  function automatic logic [PTR_W-1:0] step_right(input logic [PTR_W-1:0] p,
                                                  input logic [SW-1:0] d);
    logic [SW-1:0] s;
    s = SW'(p) + d;
    if (s >= CELLS) s = s - CELLS;
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] step_left(input logic [PTR_W-1:0] p,
                                                 input logic [SW-1:0] d);
    logic [SW-1:0] s;
    s = SW'(p) + CELLS - d;
    if (s >= CELLS) s = s - CELLS;
    return s[PTR_W-1:0];
  endfunction

  // reduce amount modulo the tape size
  always_comb begin
    rem = amount;
    for (int k = 7; k >= 0; k--) begin
      if ((TAPE_CELLS << k) < 256) begin
        if (rem >= 8'(TAPE_CELLS << k)) rem = rem - 8'(TAPE_CELLS << k);
      end
    end
  end

  always_comb begin
    cmd     = '{op: OP_NONE, operand: 8'd0, target: 16'd0};
    ptr_nxt = ptr_r;
    unique case (mode) inside
      MODE_RIGHT:   ptr_nxt = step_right(ptr_r, SW'(1));
      MODE_RIGHT_N: ptr_nxt = step_right(ptr_r, SW'(rem));
      MODE_LEFT:    ptr_nxt = step_left(ptr_r, SW'(1));
      MODE_LEFT_N:  ptr_nxt = step_left(ptr_r, SW'(rem));
      MODE_INC: begin
        cmd.op      = OP_ADD;
        cmd.operand = 8'd1;
      end
      MODE_ADD: begin
        cmd.op      = OP_ADD;
        cmd.operand = amount;
      end
      MODE_DEC: begin
        cmd.op      = OP_ADD;
        cmd.operand = 8'hFF;
      end
      MODE_SUB: begin
        cmd.op      = OP_ADD;
        cmd.operand = ~amount + 8'd1;
      end
      MODE_PRINT: cmd.op = OP_PRINT;
      MODE_STORE: begin
        cmd.op      = OP_SET;
        cmd.operand = in_byte;
      end
      MODE_JUMP: begin
        cmd.op     = OP_JUMP;
        cmd.target = target & TGT_MASK;
      end
      MODE_JZ: begin
        cmd.op     = OP_JZ;
        cmd.target = target & TGT_MASK;
      end
      default: ;
    endcase
  end

  assign addr = ptr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (acc) begin
      ptr_r <= ptr_nxt;
    end
  end

endmodule

### rtl/tme_back.sv
// Back end: tape clear, read-modify-write execute with forwarding, result FIFO.
// Depends on tme_pkg and tme_ram.
module tme_back #(
  parameter int TAPE_CELLS = 32768
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  tme_pkg::cmd_t                 q_cmd,
  input  logic [$clog2(TAPE_CELLS)-1:0] q_addr,
  output logic                          q_pop,
  output tme_pkg::back_stat_t           stat,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_out_valid,
  output logic [7:0]                    out_out_byte,
  output logic                          out_take_jump,
  output logic [15:0]                   out_next_target
);

  import tme_pkg::*;

  localparam int PTR_W = $clog2(TAPE_CELLS);
  localparam int OAW   = $clog2(OUT_DEPTH);

  localparam logic CLR_BUSY = 1'b0;
  localparam logic CLR_RUN  = 1'b1;

  logic             st_r;
  logic [PTR_W-1:0] clr_cnt_r;
  logic             clearing;

  logic             e2_v_r;
  cmd_t             e2_cmd_r;
  logic [PTR_W-1:0] e2_addr_r;

  logic             lw_v_r;
  logic [PTR_W-1:0] lw_addr_r;
  logic [7:0]       lw_data_r;

  logic             ram_we;
  logic [PTR_W-1:0] ram_waddr;
  logic [7:0]       ram_wdata, ram_rdata;

  logic [7:0]       cur_val, new_val;
  logic             we_item;
  res_t             res;

  res_t              of_mem_r [OUT_DEPTH];
  logic [OAW-1:0]    of_wr_r, of_rd_r;
  logic [OCNT_W-1:0] ocnt_r;
  logic              of_push, of_pop;

  assign clearing = (st_r == CLR_BUSY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= CLR_BUSY;
      clr_cnt_r <= '0;
    end else begin
      unique case (st_r)
        CLR_BUSY: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == PTR_W'(TAPE_CELLS - 1)) begin
            st_r <= CLR_RUN;
          end
        end
        CLR_RUN: ;
        default: st_r <= CLR_BUSY;
      endcase
    end
  end

  // issue only when the result FIFO has room for everything in flight
  assign q_pop = !clearing && !q_empty &&
                 ((OCNT_W + 1)'(ocnt_r) + (OCNT_W + 1)'(e2_v_r) < (OCNT_W + 1)'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e2_v_r <= 1'b0;
    end else begin
      e2_v_r <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      e2_cmd_r  <= q_cmd;
      e2_addr_r <= q_addr;
    end
  end

  tme_ram #(.W(8), .DEPTH(TAPE_CELLS)) u_tape (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (q_addr),
    .rdata (ram_rdata)
  );

  // forward the last write over the stale read
  assign cur_val = (lw_v_r && (lw_addr_r == e2_addr_r)) ? lw_data_r : ram_rdata;

  always_comb begin
    new_val = cur_val;
    we_item = 1'b0;
    res     = '{printed: 1'b0, obyte: 8'd0, take: 1'b0, tgt: 16'd0};
    unique case (e2_cmd_r.op)
      OP_ADD: begin
        we_item = 1'b1;
        new_val = cur_val + e2_cmd_r.operand;
      end
      OP_SET: begin
        we_item = 1'b1;
        new_val = e2_cmd_r.operand;
      end
      OP_PRINT: begin
        res.printed = 1'b1;
        res.obyte   = cur_val;
      end
      OP_JUMP: begin
        res.take = 1'b1;
        res.tgt  = e2_cmd_r.target;
      end
      OP_JZ: begin
        if (cur_val == 8'd0) begin
          res.take = 1'b1;
          res.tgt  = e2_cmd_r.target;
        end
      end
      OP_NONE: ;
      default: ;
    endcase
  end

  assign ram_we    = clearing || (e2_v_r && we_item);
  assign ram_waddr = clearing ? clr_cnt_r : e2_addr_r;
  assign ram_wdata = clearing ? 8'd0 : new_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_v_r <= 1'b0;
    end else if (e2_v_r && we_item) begin
      lw_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (e2_v_r && we_item) begin
      lw_addr_r <= e2_addr_r;
      lw_data_r <= new_val;
    end
  end

  assign of_push = e2_v_r;
  assign of_pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (of_push) begin
      of_mem_r[of_wr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      of_wr_r <= '0;
      of_rd_r <= '0;
      ocnt_r  <= '0;
    end else begin
      if (of_push) begin
        of_wr_r <= (of_wr_r == OAW'(OUT_DEPTH - 1)) ? '0 : of_wr_r + 1'b1;
      end
      if (of_pop) begin
        of_rd_r <= (of_rd_r == OAW'(OUT_DEPTH - 1)) ? '0 : of_rd_r + 1'b1;
      end
      case ({of_push, of_pop})
        2'b10:   ocnt_r <= ocnt_r + 1'b1;
        2'b01:   ocnt_r <= ocnt_r - 1'b1;
        default: ocnt_r <= ocnt_r;
      endcase
    end
  end

  assign out_valid       = (ocnt_r != '0);
  assign out_out_valid   = of_mem_r[of_rd_r].printed;
  assign out_out_byte    = of_mem_r[of_rd_r].obyte;
  assign out_take_jump   = of_mem_r[of_rd_r].take;
  assign out_next_target = of_mem_r[of_rd_r].tgt;

  assign stat.clearing = clearing;
  assign stat.e2_v     = e2_v_r;
  assign stat.ocount   = ocnt_r;

endmodule

### rtl/tape_machine_execute_unit_top.sv
// Tape machine execute unit, top level.
// Depends on tme_pkg, tme_front, tme_queue, tme_back and the defines header.
//
// Usage:
// - Input channel (in_valid / in_stall): one decoded instruction per beat,
//   fields in_mode, in_amount, in_target, in_in_byte.
// - Result channel (out_valid / out_stall): exactly one result beat per
//   input beat, in order: out_out_valid, out_out_byte, out_take_jump,
//   out_next_target.
// - Throughput: one instruction per cycle while nothing stalls; the tape
//   RAM does one read and one write per cycle and the last write is
//   forwarded to the next read.
// - Registered path: command queue, tape read, execute into the result FIFO.
// - Reset: the pointer goes to zero, then the tape is zeroed one cell per
//   cycle, all TAPE_CELLS cells, with in_stall held high.
// - When out_stall is high, results collect in a 4-deep FIFO; the execute
//   stage stops issuing once the FIFO has no room for the results in
//   flight, and the 2-deep command queue then fills and raises in_stall.
`include "tape_machine_execute_unit_top_defines.svh"

module tape_machine_execute_unit_top #(
  parameter int TAPE_CELLS        = 32768,
  parameter int PROGRAM_ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_mode,
  input  logic [7:0]  in_amount,
  input  logic [15:0] in_target,
  input  logic [7:0]  in_in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_out_valid,
  output logic [7:0]  out_out_byte,
  output logic        out_take_jump,
  output logic [15:0] out_next_target
);

  import tme_pkg::*;

  localparam int PTR_W = $clog2(TAPE_CELLS);
  localparam int QW    = PTR_W + $bits(cmd_t);

  logic             acc;
  cmd_t             f_cmd, q_cmd;
  logic [PTR_W-1:0] f_addr, q_addr;
  logic [QW-1:0]    q_head;
  logic             q_full, q_empty, q_pop;
  back_stat_t       stat;

  assign in_stall = q_full || stat.clearing;
  assign acc      = in_valid && !in_stall;

  tme_front #(
    .TAPE_CELLS        (TAPE_CELLS),
    .PROGRAM_ADDR_BITS (PROGRAM_ADDR_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .mode    (in_mode),
    .amount  (in_amount),
    .target  (in_target),
    .in_byte (in_in_byte),
    .cmd     (f_cmd),
    .addr    (f_addr)
  );

  tme_queue #(.W(QW), .DEPTH(QDEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc),
    .push_data ({f_addr, f_cmd}),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign q_addr = q_head[QW-1 -: PTR_W];
  assign q_cmd  = cmd_t'(q_head[$bits(cmd_t)-1:0]);

  tme_back #(.TAPE_CELLS(TAPE_CELLS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_cmd           (q_cmd),
    .q_addr          (q_addr),
    .q_pop           (q_pop),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_out_valid   (out_out_valid),
    .out_out_byte    (out_out_byte),
    .out_take_jump   (out_take_jump),
    .out_next_target (out_next_target)
  );

  `TME_ASSERT_IMPL(a_no_result_while_clearing, out_valid, !stat.clearing, "result during tape clear")
  `TME_ASSERT_NEXT(a_pop_enters_execute, q_pop, stat.e2_v, "popped command lost before execute")
  `TME_ASSERT_IMPL(a_result_fifo_room, stat.e2_v && !(out_valid && !out_stall), stat.ocount < OCNT_W'(OUT_DEPTH), "result FIFO overflow")

endmodule
